[rtl/axis_homing_sequencer_macros.svh]
// Assertion helpers used by the checker module.
`ifndef AXIS_HOMING_SEQUENCER_MACROS_SVH
`define AXIS_HOMING_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ahs assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ahs assertion failed");

`endif

[rtl/ahs_pkg.sv]
`default_nettype none

package ahs_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 32;

  localparam logic [CfgIndexW-1:0] CFG_COARSE_SPEED   = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_FINE_SPEED     = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_MIDPOINT_SPEED = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_COARSE_TIMEOUT = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_BACKOFF_TIME   = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_FINE_TIMEOUT   = 3'd5;
  localparam logic [CfgIndexW-1:0] CFG_TARGET_POS     = 3'd6;

  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_SEEK     = 3'd1;
  localparam logic [2:0] PH_REVERSE  = 3'd2;
  localparam logic [2:0] PH_FINE     = 3'd3;
  localparam logic [2:0] PH_COMPLETE = 3'd4;
  localparam logic [2:0] PH_ABORT    = 3'd5;
  localparam logic [2:0] PH_BAD      = 3'd7;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_PHASE   = 2'd2;

  typedef enum logic [5:0] {
    ST_START    = 6'b000001,
    ST_SEEK     = 6'b000010,
    ST_REVERSE  = 6'b000100,
    ST_FINE     = 6'b001000,
    ST_COMPLETE = 6'b010000,
    ST_ABORT    = 6'b100000
  } state_t;

endpackage

`default_nettype wire

[rtl/axis_homing_sequencer.sv]
`default_nettype none

// Homing sequencer for one axis. Each input word is either a restart or a control
// tick carrying the millisecond time, the limit switch level and the zeroed position;
// every word yields exactly one result word with the held speed command, stop and
// zero pulses, the position-good flag, an error code and the phase. The step logic
// sits between the input handshake and the result register, so a new word is
// accepted every cycle as long as the result register is empty or being drained.
// Configuration writes take effect on the next cycle and must only be issued while
// no result is pending.
module axis_homing_sequencer
  import ahs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 cfg_we,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_wdata,

  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic                 in_operation,
  input  wire logic [31:0]          in_now_ms,
  input  wire logic                 in_limit_switch,
  input  wire logic signed [31:0]   in_position,

  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic signed [15:0]   out_speed_command,
  output      logic                 out_stop_pulse,
  output      logic                 out_zero_pulse,
  output      logic                 out_position_good,
  output      logic [1:0]           out_error_code,
  output      logic [2:0]           out_phase
);

  logic [14:0]        coarse_speed_r;
  logic [14:0]        fine_speed_r;
  logic signed [15:0] midpoint_speed_r;
  logic [31:0]        coarse_timeout_r;
  logic [31:0]        backoff_time_r;
  logic [31:0]        fine_timeout_r;
  logic signed [31:0] target_pos_r;

  state_t             state_r, state_nxt;
  logic [31:0]        start_ms_r, start_ms_nxt;
  logic signed [15:0] speed_r, speed_nxt;

  logic               out_valid_r;
  logic signed [15:0] speed_out_r;
  logic               stop_r, zero_r, good_r;
  logic [1:0]         err_r;
  logic [2:0]         phase_r;

  logic               stop_nxt, zero_nxt, good_nxt;
  logic [1:0]         err_nxt;
  logic [2:0]         phase_nxt;
  logic [31:0]        elapsed;
  logic               in_accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign elapsed   = in_now_ms - start_ms_r;

  always_comb begin
    state_nxt    = state_r;
    start_ms_nxt = start_ms_r;
    speed_nxt    = speed_r;
    stop_nxt     = 1'b0;
    zero_nxt     = 1'b0;
    good_nxt     = 1'b0;
    err_nxt      = ERR_NONE;
    if (!in_operation) begin
      state_nxt = ST_START;
    end else begin
      unique case (state_r)
        ST_START: begin
          speed_nxt    = 16'sd0 - $signed({1'b0, coarse_speed_r});
          start_ms_nxt = in_now_ms;
          state_nxt    = ST_SEEK;
        end
        ST_SEEK: begin
          if (in_limit_switch) begin
            speed_nxt    = $signed({1'b0, coarse_speed_r});
            start_ms_nxt = in_now_ms;
            state_nxt    = ST_REVERSE;
          end else if (elapsed > coarse_timeout_r) begin
            speed_nxt = '0;
            state_nxt = ST_ABORT;
          end
        end
        ST_REVERSE: begin
          if (elapsed >= backoff_time_r) begin
            speed_nxt    = 16'sd0 - $signed({1'b0, fine_speed_r});
            start_ms_nxt = in_now_ms;
            state_nxt    = ST_FINE;
          end
        end
        ST_FINE: begin
          if (in_limit_switch) begin
            stop_nxt  = 1'b1;
            zero_nxt  = 1'b1;
            speed_nxt = midpoint_speed_r;
            state_nxt = ST_COMPLETE;
          end else if (elapsed > fine_timeout_r) begin
            speed_nxt = '0;
            state_nxt = ST_ABORT;
          end
        end
        ST_COMPLETE: begin
          if (in_position >= target_pos_r) begin
            speed_nxt = '0;
            good_nxt  = 1'b1;
          end
        end
        ST_ABORT: begin
          speed_nxt = '0;
          err_nxt   = ERR_TIMEOUT;
        end
        default: begin
          speed_nxt = '0;
          err_nxt   = ERR_PHASE;
        end
      endcase
    end
  end

  always_comb begin
    unique case (state_nxt)
      ST_START:    phase_nxt = PH_START;
      ST_SEEK:     phase_nxt = PH_SEEK;
      ST_REVERSE:  phase_nxt = PH_REVERSE;
      ST_FINE:     phase_nxt = PH_FINE;
      ST_COMPLETE: phase_nxt = PH_COMPLETE;
      ST_ABORT:    phase_nxt = PH_ABORT;
      default:     phase_nxt = PH_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coarse_speed_r   <= '0;
      fine_speed_r     <= '0;
      midpoint_speed_r <= '0;
      coarse_timeout_r <= '0;
      backoff_time_r   <= '0;
      fine_timeout_r   <= '0;
      target_pos_r     <= '0;
      state_r          <= ST_START;
      start_ms_r       <= '0;
      speed_r          <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COARSE_SPEED:   coarse_speed_r   <= cfg_wdata[14:0];
          CFG_FINE_SPEED:     fine_speed_r     <= cfg_wdata[14:0];
          CFG_MIDPOINT_SPEED: midpoint_speed_r <= $signed(cfg_wdata[15:0]);
          CFG_COARSE_TIMEOUT: coarse_timeout_r <= cfg_wdata;
          CFG_BACKOFF_TIME:   backoff_time_r   <= cfg_wdata;
          CFG_FINE_TIMEOUT:   fine_timeout_r   <= cfg_wdata;
          CFG_TARGET_POS:     target_pos_r     <= $signed(cfg_wdata);
          default: ;
        endcase
      end
      if (in_accept) begin
        state_r     <= state_nxt;
        start_ms_r  <= start_ms_nxt;
        speed_r     <= speed_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      speed_out_r <= speed_nxt;
      stop_r      <= stop_nxt;
      zero_r      <= zero_nxt;
      good_r      <= good_nxt;
      err_r       <= err_nxt;
      phase_r     <= phase_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_speed_command = speed_out_r;
  assign out_stop_pulse    = stop_r;
  assign out_zero_pulse    = zero_r;
  assign out_position_good = good_r;
  assign out_error_code    = err_r;
  assign out_phase         = phase_r;

endmodule

`default_nettype wire

[rtl/ahs_checker.sv]
`default_nettype none

`include "axis_homing_sequencer_macros.svh"

module ahs_checker
  import ahs_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic signed [15:0]   out_speed_command,
  input wire logic                 out_stop_pulse,
  input wire logic                 out_zero_pulse,
  input wire logic                 out_position_good,
  input wire logic [1:0]           out_error_code,
  input wire logic [2:0]           out_phase
);

  `AHS_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(out_speed_command) && $stable(out_phase))

  // stop and zero only on the fine-to-complete transition
  `AHS_ASSERT_IMP(a_stop_zero, out_valid && (out_stop_pulse || out_zero_pulse),
                  out_stop_pulse && out_zero_pulse && out_phase == PH_COMPLETE)

  `AHS_ASSERT_IMP(a_timeout_err, out_valid && out_error_code == ERR_TIMEOUT,
                  out_phase == PH_ABORT && out_speed_command == 16'sd0)

  `AHS_ASSERT_IMP(a_good, out_valid && out_position_good,
                  out_phase == PH_COMPLETE && out_speed_command == 16'sd0 &&
                  out_error_code == ERR_NONE)

endmodule

bind axis_homing_sequencer ahs_checker u_ahs_checker (.*);

`default_nettype wire

[dv/axis_homing_sequencer_test.sv]
`default_nettype none

module axis_homing_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ahs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int WORDS_PER_PHASE = 155;
  localparam int RANDOM_PHASES = 10;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic               op;
    logic [31:0]        now_ms;
    logic               sw;
    logic signed [31:0] pos;
  } homing_word_t;

  typedef struct packed {
    logic signed [15:0] speed;
    logic               stop;
    logic               zero;
    logic               good;
    logic [1:0]         err;
    logic [2:0]         phase;
  } drive_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  logic               in_valid = 1'b0;
  wire                in_ready;
  logic               in_operation = 1'b0;
  logic [31:0]        in_now_ms = '0;
  logic               in_limit_switch = 1'b0;
  logic signed [31:0] in_position = '0;

  wire               out_valid;
  logic              out_ready = 1'b0;
  wire signed [15:0] out_speed_command;
  wire               out_stop_pulse;
  wire               out_zero_pulse;
  wire               out_position_good;
  wire [1:0]         out_error_code;
  wire [2:0]         out_phase;

  // register copies
  logic [14:0]        r_coarse = '0;
  logic [14:0]        r_fine = '0;
  logic [15:0]        r_mid = '0;
  logic [31:0]        r_coarse_to = '0;
  logic [31:0]        r_backoff = '0;
  logic [31:0]        r_fine_to = '0;
  logic signed [31:0] r_target = '0;

  // sequencer state copy
  logic [2:0]  hs_phase = PH_START;
  logic [31:0] hs_mark_ms = '0;
  logic [15:0] hs_speed = '0;

  homing_word_t  word_q[$];
  drive_status_t due_status_q[$];

  int  words_queued = 0;
  int  fail_count = 0;
  int  cycle_cnt = 0;
  int  in_gap = 0;
  int  out_stall = 0;
  int  in_idle_mode = 0;
  int  out_idle_mode = 0;
  bit  in_taken = 1'b0;

  axis_homing_sequencer uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_now_ms(in_now_ms),
    .in_limit_switch(in_limit_switch),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_speed_command(out_speed_command),
    .out_stop_pulse(out_stop_pulse),
    .out_zero_pulse(out_zero_pulse),
    .out_position_good(out_position_good),
    .out_error_code(out_error_code),
    .out_phase(out_phase)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic drive_status_t advance_homing(homing_word_t w);
    drive_status_t s;
    logic [31:0]   elapsed;
    s = '0;
    s.err = ERR_NONE;
    elapsed = w.now_ms - hs_mark_ms;
    if (w.op == OP_RESTART) begin
      hs_phase = PH_START;
    end else begin
      case (hs_phase)
        PH_START: begin
          hs_speed = 16'd0 - {1'b0, r_coarse};
          hs_mark_ms = w.now_ms;
          hs_phase = PH_SEEK;
        end
        PH_SEEK: begin
          if (w.sw) begin
            hs_speed = {1'b0, r_coarse};
            hs_mark_ms = w.now_ms;
            hs_phase = PH_REVERSE;
          end else if (elapsed > r_coarse_to) begin
            hs_speed = '0;
            hs_phase = PH_ABORT;
          end
        end
        PH_REVERSE: begin
          if (elapsed >= r_backoff) begin
            hs_speed = 16'd0 - {1'b0, r_fine};
            hs_mark_ms = w.now_ms;
            hs_phase = PH_FINE;
          end
        end
        PH_FINE: begin
          if (w.sw) begin
            s.stop = 1'b1;
            s.zero = 1'b1;
            hs_speed = r_mid;
            hs_phase = PH_COMPLETE;
          end else if (elapsed > r_fine_to) begin
            hs_speed = '0;
            hs_phase = PH_ABORT;
          end
        end
        PH_COMPLETE: begin
          if ($signed(w.pos) >= $signed(r_target)) begin
            hs_speed = '0;
            s.good = 1'b1;
          end
        end
        PH_ABORT: begin
          hs_speed = '0;
          s.err = ERR_TIMEOUT;
        end
        default: begin
          hs_speed = '0;
          s.err = ERR_PHASE;
        end
      endcase
    end
    s.speed = hs_speed;
    s.phase = hs_phase;
    return s;
  endfunction

  function automatic int pick_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (r < 4 * mode) return $urandom_range(8, 40);
    if (r < 25 * mode) return $urandom_range(1, 3);
    return 0;
  endfunction

  // mostly well inside the limit, sometimes right on it
  function automatic logic [31:0] near_limit(logic [31:0] lim);
    if ($urandom_range(0, 3) == 0) return lim;
    return 32'($urandom_range(0, lim >> 3));
  endfunction

  function automatic logic [31:0] near_target();
    case ($urandom_range(0, 3))
      0: return r_target + 32'($urandom_range(0, 4)) - 32'd2;
      1: return r_target;
      2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_setting(int width, bit is_signed);
    logic [31:0] v;
    logic [31:0] mask;
    mask = (width == 32) ? '1 : ((32'd1 << width) - 32'd1);
    case ($urandom_range(0, 3))
      0: v = is_signed ? (32'd1 << (width - 1)) : 32'd0;
      1: v = is_signed ? ((32'd1 << (width - 1)) - 32'd1) : mask;
      2: v = is_signed ? 32'($urandom_range(0, 40)) - 32'd20 : 32'($urandom_range(0, 20));
      default: v = $urandom();
    endcase
    return (v & mask) | ($urandom() & ~mask);
  endfunction

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      CFG_COARSE_SPEED:   r_coarse = data[14:0];
      CFG_FINE_SPEED:     r_fine = data[14:0];
      CFG_MIDPOINT_SPEED: r_mid = data[15:0];
      CFG_COARSE_TIMEOUT: r_coarse_to = data;
      CFG_BACKOFF_TIME:   r_backoff = data;
      CFG_FINE_TIMEOUT:   r_fine_to = data;
      CFG_TARGET_POS:     r_target = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic queue_word(logic op, logic [31:0] now_ms, logic sw, logic [31:0] pos);
    word_q.push_back('{op, now_ms, sw, pos});
    words_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || due_status_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // approach toward the switch: quiet ticks, then either a hit or a timeout
  task automatic queue_approach(inout logic [31:0] mark, input logic [31:0] lim,
                                output bit timed_out);
    timed_out = 1'b0;
    repeat ($urandom_range(0, 4))
      queue_word(OP_TICK, mark + near_limit(lim), 1'b0, $urandom());
    if (lim < 32'hFFFF_FFF0 && $urandom_range(0, 7) == 0) begin
      queue_word(OP_TICK, mark + lim + 32'($urandom_range(1, 4)), 1'b0, $urandom());
      repeat ($urandom_range(1, 3))
        queue_word(OP_TICK, $urandom(), 1'($urandom()), $urandom());
      timed_out = 1'b1;
    end else begin
      mark = mark + near_limit(lim);
      queue_word(OP_TICK, mark, 1'b1, $urandom());
    end
  endtask

  task automatic queue_homing_run();
    logic [31:0] mark;
    bit          aborted;
    if ($urandom_range(0, 3) != 0)
      queue_word(OP_RESTART, $urandom(), 1'($urandom()), $urandom());
    mark = $urandom();
    queue_word(OP_TICK, mark, 1'($urandom()), $urandom());
    queue_approach(mark, r_coarse_to, aborted);
    if (aborted) return;
    if (r_backoff != 0)
      repeat ($urandom_range(0, 3))
        queue_word(OP_TICK, mark + 32'($urandom_range(0, r_backoff - 1)), 1'($urandom()),
                   $urandom());
    if (r_backoff < 32'hFFFF_FFF0) mark = mark + r_backoff + 32'($urandom_range(0, 3));
    else mark = mark + r_backoff;
    queue_word(OP_TICK, mark, 1'($urandom()), $urandom());
    queue_approach(mark, r_fine_to, aborted);
    if (aborted) return;
    repeat ($urandom_range(1, 6))
      queue_word(OP_TICK, $urandom(), 1'($urandom()), near_target());
  endtask

  always @(negedge clk) begin : drive_words
    homing_word_t w;
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        w = word_q.pop_front();
        in_operation <= w.op;
        in_now_ms <= w.now_ms;
        in_limit_switch <= w.sw;
        in_position <= w.pos;
        in_valid <= 1'b1;
        in_gap = pick_gap(in_idle_mode);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_stall = pick_gap(out_idle_mode);
    end
  end

  always @(posedge clk) begin : watch_ports
    drive_status_t got;
    drive_status_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.speed = out_speed_command;
        got.stop = out_stop_pulse;
        got.zero = out_zero_pulse;
        got.good = out_position_good;
        got.err = out_error_code;
        got.phase = out_phase;
        if (due_status_q.size() == 0) begin
          $error("result word with none expected");
          fail_count++;
        end else begin
          want = due_status_q.pop_front();
          if (got.speed !== want.speed) begin
            $error("speed_command expected %0d got %0d", want.speed, got.speed);
            fail_count++;
          end
          if (got.stop !== want.stop) begin
            $error("stop_pulse expected %0d got %0d", want.stop, got.stop);
            fail_count++;
          end
          if (got.zero !== want.zero) begin
            $error("zero_pulse expected %0d got %0d", want.zero, got.zero);
            fail_count++;
          end
          if (got.good !== want.good) begin
            $error("position_good expected %0d got %0d", want.good, got.good);
            fail_count++;
          end
          if (got.err !== want.err) begin
            $error("error_code expected %0d got %0d", want.err, got.err);
            fail_count++;
          end
          if (got.phase !== want.phase) begin
            $error("phase expected %0d got %0d", want.phase, got.phase);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        due_status_q.push_back(advance_homing('{in_operation, in_now_ms, in_limit_switch,
                                                in_position}));
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("axis_homing_sequencer_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    int p;
    int goal;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    in_idle_mode = 1;
    out_idle_mode = 1;
    write_reg(CFG_COARSE_SPEED, 32'h0000_7FFF);
    write_reg(CFG_FINE_SPEED, 32'd1);
    write_reg(CFG_MIDPOINT_SPEED, 32'hFFFF_8000);
    write_reg(CFG_COARSE_TIMEOUT, 32'd100);
    write_reg(CFG_BACKOFF_TIME, 32'd50);
    write_reg(CFG_FINE_TIMEOUT, 32'd0);
    write_reg(CFG_TARGET_POS, 32'd0);

    // full homing pass, limits hit exactly
    queue_word(OP_TICK, 32'd0, 1'b0, 32'd0);
    queue_word(OP_TICK, 32'd100, 1'b0, 32'd5);
    queue_word(OP_TICK, 32'd101, 1'b1, 32'd5);
    queue_word(OP_TICK, 32'd150, 1'b1, 32'd7);
    queue_word(OP_TICK, 32'd151, 1'b0, 32'd7);
    queue_word(OP_TICK, 32'd151, 1'b0, 32'd9);
    queue_word(OP_TICK, 32'd200, 1'b1, 32'hFFFF_FFFF);
    queue_word(OP_TICK, 32'd201, 1'b0, 32'hFFFF_FFFF);
    queue_word(OP_TICK, 32'd202, 1'b0, 32'd0);
    // coarse timeout across the time wrap, then abort
    queue_word(OP_RESTART, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
    queue_word(OP_TICK, 32'hFFFF_FFF0, 1'b0, 32'd0);
    queue_word(OP_TICK, 32'h0000_0060, 1'b0, 32'd0);
    queue_word(OP_TICK, 32'h0000_0061, 1'b1, 32'h7FFF_FFFF);
    // fine timeout
    queue_word(OP_RESTART, 32'd0, 1'b0, 32'd0);
    queue_word(OP_TICK, 32'd10, 1'b0, 32'd0);
    queue_word(OP_TICK, 32'd20, 1'b1, 32'd0);
    queue_word(OP_TICK, 32'd70, 1'b0, 32'd0);
    queue_word(OP_TICK, 32'd71, 1'b0, 32'd0);
    queue_word(OP_TICK, 32'd72, 1'b0, 32'd0);
    wait_idle();

    write_reg(CFG_COARSE_SPEED, 32'd0);
    write_reg(CFG_FINE_SPEED, 32'hFFFF_7FFF);
    write_reg(CFG_MIDPOINT_SPEED, 32'h0000_7FFF);
    write_reg(CFG_COARSE_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_BACKOFF_TIME, 32'd0);
    write_reg(CFG_FINE_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_TARGET_POS, 32'h8000_0000);
    queue_word(OP_RESTART, 32'd0, 1'b0, 32'd0);
    queue_word(OP_TICK, 32'd5, 1'b0, 32'd0);
    queue_word(OP_TICK, 32'd4, 1'b1, 32'd0);
    queue_word(OP_TICK, 32'd4, 1'b0, 32'd0);
    queue_word(OP_TICK, 32'd3, 1'b0, 32'd0);
    queue_word(OP_TICK, 32'd9, 1'b1, 32'd0);
    queue_word(OP_TICK, 32'd9, 1'b0, 32'h8000_0000);
    wait_idle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      in_idle_mode = (p == 0) ? 0 : $urandom_range(0, 2);
      out_idle_mode = (p == 0) ? 0 : $urandom_range(0, 2);
      write_reg(CFG_COARSE_SPEED, pick_setting(15, 1'b0));
      write_reg(CFG_FINE_SPEED, pick_setting(15, 1'b0));
      write_reg(CFG_MIDPOINT_SPEED, pick_setting(16, 1'b1));
      write_reg(CFG_COARSE_TIMEOUT, pick_setting(32, 1'b0));
      write_reg(CFG_BACKOFF_TIME, pick_setting(32, 1'b0));
      write_reg(CFG_FINE_TIMEOUT, pick_setting(32, 1'b0));
      write_reg(CFG_TARGET_POS, pick_setting(32, 1'b1));
      goal = words_queued + WORDS_PER_PHASE;
      while (words_queued < goal) begin
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 3))
            queue_word(1'($urandom()), $urandom(), 1'($urandom()), $urandom());
        else
          queue_homing_run();
      end
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("axis_homing_sequencer_test OK");
    else
      $display("axis_homing_sequencer_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
